>>> sv/skf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Scalar Kalman filter package
// Shared widths, register indexes, defaults and the control state type.
// ----------------------------------------------------------------------------
package skf_pkg;

   localparam int DATA_W          = 32;
   localparam int CSR_INDEX_W     = 1;
   localparam int DEF_FRAC_BITS   = 16;
   localparam int DEF_SAMPLE_BITS = 16;

   typedef logic [CSR_INDEX_W-1:0] csr_index_type;
   typedef logic [DATA_W-1:0]      data_type;

   localparam csr_index_type CSR_PROCESS_NOISE     = 1'd0;
   localparam csr_index_type CSR_MEASUREMENT_NOISE = 1'd1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PRED,
      ST_DSET,
      ST_DIV,
      ST_MSET,
      ST_MUL,
      ST_WRITE
   } state_type;

endpackage
`default_nettype wire

>>> sv/scalar_kalman_filter.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Scalar Kalman filter
// One-dimensional Kalman filter on signed integer samples, Q16.16 state.
//
// Request channel: req_valid / req_stall carry one signed sample. Response
// channel: rsp_valid / rsp_stall carry one signed Q16.16 estimate per sample.
// The csr_ port writes process_noise (index 0) and measurement_noise
// (index 1), unsigned Q16.16, one write per cycle with csr_wr_en.
//
// One request at a time. The gain comes from a restoring divider that
// retires one quotient bit per cycle, and both products come from
// shift-add multipliers that take one bit of the gain or of its complement
// per cycle; a zero divisor skips the divider.
// A new request is taken in the cycle after the result is loaded into the
// response register, so a held response does not block the next request.
// If the response register is still full and stalled, write-back waits.
// Reset sets the estimate to 0, the covariance and both noises to 1.0,
// and empties the response register.
// ----------------------------------------------------------------------------
module scalar_kalman_filter #(
   parameter int FRAC_BITS   = skf_pkg::DEF_FRAC_BITS,
   parameter int SAMPLE_BITS = skf_pkg::DEF_SAMPLE_BITS
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output      logic                          req_stall,
   input  wire logic signed [SAMPLE_BITS-1:0] req_sample,
   output      logic                          rsp_valid,
   input  wire logic                          rsp_stall,
   output      logic signed [31:0]            rsp_estimate,
   input  wire logic                          csr_wr_en,
   input  wire skf_pkg::csr_index_type        csr_index,
   input  wire skf_pkg::data_type             csr_wr_data
);
   import skf_pkg::*;

   localparam int GW  = FRAC_BITS + 1;
   localparam int CW  = $clog2(GW);
   localparam int XW  = SAMPLE_BITS + FRAC_BITS;
   localparam int XEW = (XW > 32) ? XW : 33;
   localparam logic [GW-1:0] GAIN_ONE = {1'b1, {FRAC_BITS{1'b0}}};
   localparam logic [CW-1:0] LAST_STEP = CW'(GW - 1);
   localparam logic signed [XEW-1:0] X_MAX = XEW'(33'sh0_7FFF_FFFF);
   localparam logic signed [XEW-1:0] X_MIN = XEW'(33'sh1_8000_0000);

   state_type state_ff, state_in;

   data_type                 qn_ff, rn_ff;
   logic signed [31:0]       est_ff, est_in;
   data_type                 cov_ff, cov_in;
   logic signed [31:0]       x_ff, x_in;
   data_type                 p_ff, p_in;
   logic [32:0]              den_ff, den_in;
   logic [33:0]              rem_ff, rem_in;
   logic [GW-1:0]            quo_ff, quo_in;
   logic [CW-1:0]            step_ff, step_in;
   logic signed [32:0]       diff_ff, diff_in;
   logic [GW-1:0]            mg_ff, mg_in;
   logic [GW-1:0]            mo_ff, mo_in;
   logic signed [34:0]       acc_e_ff, acc_e_in;
   logic [32:0]              acc_c_ff, acc_c_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic signed [31:0]       rsp_est_ff, rsp_est_in;

   logic signed [XW-1:0]     x_wide;
   logic signed [XEW-1:0]    x_ext;
   logic signed [31:0]       x_sat;
   logic [32:0]              p_sum;
   logic                     ge;
   logic [33:0]              rem_sub;
   logic signed [34:0]       e_sum;
   logic [32:0]              c_sum;
   logic                     rsp_free;

   assign req_stall    = (state_ff != ST_IDLE);
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_estimate = rsp_est_ff;
   assign rsp_free     = !rsp_valid_ff || !rsp_stall;

   // scale the sample and clamp to the 32-bit range
   always_comb begin
      x_wide = {req_sample, {FRAC_BITS{1'b0}}};
      x_ext  = XEW'(x_wide);
      if (x_ext > X_MAX) begin
         x_sat = 32'sh7FFF_FFFF;
      end else if (x_ext < X_MIN) begin
         x_sat = $signed(32'h8000_0000);
      end else begin
         x_sat = x_ext[31:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         qn_ff        <= DATA_W'(GAIN_ONE);
         rn_ff        <= DATA_W'(GAIN_ONE);
         est_ff       <= '0;
         cov_ff       <= DATA_W'(GAIN_ONE);
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en && csr_index == CSR_PROCESS_NOISE) begin
            qn_ff <= csr_wr_data;
         end
         if (csr_wr_en && csr_index == CSR_MEASUREMENT_NOISE) begin
            rn_ff <= csr_wr_data;
         end
         est_ff       <= est_in;
         cov_ff       <= cov_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff       <= x_in;
      p_ff       <= p_in;
      den_ff     <= den_in;
      rem_ff     <= rem_in;
      quo_ff     <= quo_in;
      step_ff    <= step_in;
      diff_ff    <= diff_in;
      mg_ff      <= mg_in;
      mo_ff      <= mo_in;
      acc_e_ff   <= acc_e_in;
      acc_c_ff   <= acc_c_in;
      rsp_est_ff <= rsp_est_in;
   end

   always_comb begin
      state_in     = state_ff;
      est_in       = est_ff;
      cov_in       = cov_ff;
      x_in         = x_ff;
      p_in         = p_ff;
      den_in       = den_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      step_in      = step_ff;
      diff_in      = diff_ff;
      mg_in        = mg_ff;
      mo_in        = mo_ff;
      acc_e_in     = acc_e_ff;
      acc_c_in     = acc_c_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_est_in   = rsp_est_ff;

      p_sum   = {1'b0, cov_ff} + {1'b0, qn_ff};
      ge      = (rem_ff >= {1'b0, den_ff});
      rem_sub = rem_ff - (ge ? {1'b0, den_ff} : 34'd0);
      e_sum   = acc_e_ff + (mg_ff[0] ? 35'(diff_ff) : 35'sd0);
      c_sum   = acc_c_ff + (mo_ff[0] ? {1'b0, p_ff} : 33'd0);

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               x_in     = x_sat;
               state_in = ST_PRED;
            end
         end
         ST_PRED: begin
            // predict covariance, saturate
            p_in     = p_sum[32] ? 32'hFFFF_FFFF : p_sum[31:0];
            diff_in  = $signed({x_ff[31], x_ff}) - $signed({est_ff[31], est_ff});
            state_in = ST_DSET;
         end
         ST_DSET: begin
            den_in  = {1'b0, p_ff} + {1'b0, rn_ff};
            rem_in  = {2'b00, p_ff};
            step_in = '0;
            if (p_ff == '0 && rn_ff == '0) begin
               quo_in   = GAIN_ONE;
               state_in = ST_MSET;
            end else begin
               quo_in   = '0;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            // one quotient bit per cycle
            quo_in = {quo_ff[GW-2:0], ge};
            rem_in = {rem_sub[32:0], 1'b0};
            if (step_ff == LAST_STEP) begin
               state_in = ST_MSET;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         ST_MSET: begin
            mg_in    = quo_ff;
            mo_in    = GAIN_ONE - quo_ff;
            acc_e_in = '0;
            acc_c_in = '0;
            step_in  = '0;
            state_in = ST_MUL;
         end
         ST_MUL: begin
            // one multiplier bit per cycle, drop the low bit after each add
            if (step_ff == LAST_STEP) begin
               est_in   = est_ff + e_sum[31:0];
               cov_in   = c_sum[31:0];
               state_in = ST_WRITE;
            end else begin
               acc_e_in = e_sum >>> 1;
               acc_c_in = c_sum >> 1;
               mg_in    = mg_ff >> 1;
               mo_in    = mo_ff >> 1;
               step_in  = step_ff + 1'b1;
            end
         end
         ST_WRITE: begin
            // hold until the response register frees up
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_est_in   = est_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule
`default_nettype wire

>>> dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Scalar Kalman filter testbench
// Drives signed samples through the filter under random request gaps and
// response stalls, steps a Q16.16 filter model for every accepted request,
// and checks each estimate in order. Noise registers are rewritten between
// phases, covering zero, saturated and random settings.
// ----------------------------------------------------------------------------
module tb;

   localparam int FRAC     = skf_pkg::DEF_FRAC_BITS;
   localparam int SAMPLE_W = skf_pkg::DEF_SAMPLE_BITS;
   localparam int HOLD_CYCLES = 300;

   typedef enum logic [1:0] {
      STALL_NONE,
      STALL_LIGHT,
      STALL_HEAVY,
      STALL_TOGGLE
   } stall_mode_type;

   logic                       clock       = 1'b0;
   logic                       reset       = 1'b1;
   logic                       req_valid   = 1'b0;
   logic                       req_stall;
   logic signed [SAMPLE_W-1:0] req_sample  = '0;
   logic                       rsp_valid;
   logic                       rsp_stall   = 1'b0;
   logic signed [31:0]         rsp_estimate;
   logic                       csr_wr_en   = 1'b0;
   skf_pkg::csr_index_type     csr_index   = skf_pkg::CSR_PROCESS_NOISE;
   skf_pkg::data_type          csr_wr_data = '0;

   scalar_kalman_filter i_dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_sample   (req_sample),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_estimate (rsp_estimate),
      .csr_wr_en    (csr_wr_en),
      .csr_index    (csr_index),
      .csr_wr_data  (csr_wr_data)
   );

   // filter model state and noise settings
   logic signed [31:0] est_state  = '0;
   logic [31:0]        err_cov    = 32'h0001_0000;
   logic [31:0]        proc_noise = 32'h0001_0000;
   logic [31:0]        meas_noise = 32'h0001_0000;

   logic signed [SAMPLE_W-1:0] sample_q[$];
   logic signed [31:0]         estimate_q[$];

   int  mismatches     = 0;
   int  samples_taken  = 0;
   int  estimates_seen = 0;
   int  zero_div_steps = 0;
   int  sat_cov_steps  = 0;
   int  settings_used  = 0;
   bit  req_fired      = 1'b0;

   int  burst_left = 0;
   int  gap_left   = 0;
   int  hold_asks  = 0;
   int  hold_done  = 0;
   int  hold_left  = 0;
   int  seg_left   = 0;
   stall_mode_type stall_mode = STALL_NONE;

   initial begin
      forever #10 clock = ~clock;
   end

   initial begin
      #20_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   function automatic logic signed [31:0] kalman_update(input logic signed [SAMPLE_W-1:0] smp);
      logic [32:0] p_sum;
      logic [63:0] p;
      logic [63:0] den;
      logic [63:0] gain;
      longint      x;
      longint      diff;
      longint      prod;
      x = longint'(smp) * (longint'(1) << FRAC);
      if (x > 64'sd2147483647) x = 64'sd2147483647;
      if (x < -64'sd2147483648) x = -64'sd2147483648;
      p_sum = {1'b0, err_cov} + {1'b0, proc_noise};
      if (p_sum[32]) begin
         p = 64'hFFFF_FFFF;
         sat_cov_steps++;
      end else begin
         p = {32'b0, p_sum[31:0]};
      end
      den = p + {32'b0, meas_noise};
      if (den == 64'd0) begin
         gain = 64'd1 << FRAC;
         zero_div_steps++;
      end else begin
         gain = (p << FRAC) / den;
      end
      diff = x - longint'(est_state);
      prod = longint'(gain) * diff;
      est_state = 32'(longint'(est_state) + (prod >>> FRAC));
      err_cov = 32'((((64'd1 << FRAC) - gain) * p) >> FRAC);
      return est_state;
   endfunction

   function automatic logic signed [SAMPLE_W-1:0] pick_sample(input int level);
      int kind;
      int v;
      kind = $urandom_range(0, 9);
      if (kind < 6) return SAMPLE_W'($urandom);
      if (kind < 8) begin
         case ($urandom_range(0, 3))
            0: return {1'b1, {(SAMPLE_W-1){1'b0}}};
            1: return {1'b0, {(SAMPLE_W-1){1'b1}}};
            2: return '0;
            default: return '1;
         endcase
      end
      v = level + int'($urandom_range(0, 400)) - 200;
      if (v > 32767) v = 32767;
      if (v < -32768) v = -32768;
      return v[SAMPLE_W-1:0];
   endfunction

   function automatic logic [31:0] pick_noise();
      case ($urandom_range(0, 5))
         0: return 32'h0;
         1: return 32'hFFFF_FFFF;
         2: return $urandom;
         3, 4: return $urandom_range(1, 32'h0010_0000);
         default: return $urandom_range(32'h0000_8000, 32'h0002_0000);
      endcase
   endfunction

   task automatic csr_write(input skf_pkg::csr_index_type idx, input logic [31:0] data);
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= data;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   task automatic set_noise(input logic [31:0] pn, input logic [31:0] mn);
      csr_write(skf_pkg::CSR_PROCESS_NOISE, pn);
      csr_write(skf_pkg::CSR_MEASUREMENT_NOISE, mn);
      proc_noise = pn;
      meas_noise = mn;
      settings_used++;
   endtask

   task automatic wait_idle();
      do @(posedge clock);
      while (sample_q.size() != 0 || req_valid || estimate_q.size() != 0);
      repeat (4) @(negedge clock);
   endtask

   // request driver: bursts of random length separated by random gaps
   always @(negedge clock) begin
      if (req_valid && !req_fired) begin
         // hold the offered request
      end else if (!reset && burst_left > 0 && sample_q.size() > 0) begin
         req_valid  <= 1'b1;
         req_sample <= sample_q.pop_front();
         burst_left--;
      end else begin
         req_valid <= 1'b0;
         if (gap_left > 0) begin
            gap_left--;
         end else begin
            burst_left = $urandom_range(1, 24);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 50);
         end
      end
   end

   // response stall pattern, with long hold-offs on request
   always @(negedge clock) begin
      if (hold_asks != hold_done) begin
         hold_left = HOLD_CYCLES;
         hold_done = hold_asks;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         if (seg_left == 0) begin
            seg_left   = $urandom_range(20, 200);
            stall_mode = stall_mode_type'($urandom_range(0, 3));
         end
         seg_left--;
         case (stall_mode)
            STALL_NONE:  rsp_stall <= 1'b0;
            STALL_LIGHT: rsp_stall <= ($urandom_range(0, 3) == 0);
            STALL_HEAVY: rsp_stall <= ($urandom_range(0, 3) != 0);
            default:     rsp_stall <= ~rsp_stall;
         endcase
      end
   end

   // step the model on each accepted request, check each accepted response
   always @(posedge clock) begin
      req_fired = !reset && req_valid && !req_stall;
      if (req_fired) begin
         estimate_q.push_back(kalman_update(req_sample));
         samples_taken++;
      end
      if (!reset && rsp_valid && !rsp_stall) begin
         estimates_seen++;
         if (estimate_q.size() == 0) begin
            $display("%0t: unexpected estimate %0d (0x%08h)", $time, rsp_estimate,
                     rsp_estimate);
            mismatches++;
         end else begin
            logic signed [31:0] want;
            want = estimate_q.pop_front();
            if (rsp_estimate !== want) begin
               $display("%0t: estimate expected %0d (0x%08h), got %0d (0x%08h)", $time,
                        want, want, rsp_estimate, rsp_estimate);
               mismatches++;
            end
         end
      end
   end

   initial begin
      int level;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // defaults after reset, full-scale steps
      sample_q.push_back(16'sd0);
      sample_q.push_back(16'sd32767);
      sample_q.push_back(-16'sd32768);
      sample_q.push_back(16'sd32767);
      sample_q.push_back(16'sd1);
      sample_q.push_back(-16'sd1);
      sample_q.push_back(16'sh5555);
      sample_q.push_back(16'shAAAA);
      wait_idle();

      // no noise: unit gain, then a zero divisor
      set_noise(32'h0, 32'h0);
      sample_q.push_back(16'sd32767);
      sample_q.push_back(-16'sd32768);
      sample_q.push_back(16'sd100);
      wait_idle();

      // saturated covariance with largest measurement noise
      set_noise(32'hFFFF_FFFF, 32'hFFFF_FFFF);
      sample_q.push_back(-16'sd32768);
      sample_q.push_back(16'sd32767);
      sample_q.push_back(16'sd0);
      wait_idle();

      // tiny gain
      set_noise(32'h0, 32'hFFFF_FFFF);
      sample_q.push_back(16'sd32767);
      sample_q.push_back(-16'sd32768);
      sample_q.push_back(16'sd5);
      wait_idle();

      // saturated covariance, no measurement noise
      set_noise(32'hFFFF_FFFF, 32'h0);
      sample_q.push_back(16'sd1234);
      sample_q.push_back(-16'sd1);
      wait_idle();

      for (int ph = 0; ph < 10; ph++) begin
         set_noise(pick_noise(), pick_noise());
         level = int'($urandom_range(0, 65535)) - 32768;
         if (ph == 2 || ph == 7) hold_asks++;
         for (int n = 0; n < 143; n++) sample_q.push_back(pick_sample(level));
         wait_idle();
      end

      repeat (50) @(negedge clock);
      $display("Covered %0d samples and %0d estimates over %0d noise settings,", samples_taken,
               estimates_seen, settings_used);
      $display("with %0d zero-divisor steps and %0d saturated covariance steps.",
               zero_div_steps, sat_cov_steps);
      if (mismatches == 0 && estimate_q.size() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
